[rtl/cbml_pkg.sv]
// ----------------------------------------------------------------------------
// cbml_pkg
// Shared types and constants for the color box multi-label classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cbml_pkg;

   localparam int CHAN_W  = 8;
   localparam int LABEL_W = 8;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int ADDR_SLOTS = 16;

   // command codes of an input item
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_RANGES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNKNOWN_LABEL = 1'd1;

   typedef logic [3*CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      rgb_type            high;
      rgb_type            low;
   } box_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // write a box entry
      logic start;         // capture pixel, rewind scan
      logic capture_first; // current box becomes the first match
      logic push_match;    // emit pending label, current box becomes pending
      logic advance;       // step to next slot
      logic emit_final;    // emit pending (or unknown) as last item
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic n_zero;
      logic j_last;
      logic hit_first;
      logic hit_more;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

[rtl/cbml_req_if.sv]
// ----------------------------------------------------------------------------
// cbml_req_if
// Input channel: box loads and pixels to classify.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbml_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [3:0] entry_index;
   logic [7:0] value_c0;
   logic [7:0] value_c1;
   logic [7:0] value_c2;
   logic [7:0] other_c0;
   logic [7:0] other_c1;
   logic [7:0] other_c2;
   logic [7:0] label_in;

   modport source (
      output valid, command, entry_index, value_c0, value_c1, value_c2,
             other_c0, other_c1, other_c2, label_in,
      input  ready
   );
   modport sink (
      input  valid, command, entry_index, value_c0, value_c1, value_c2,
             other_c0, other_c1, other_c2, label_in,
      output ready
   );
endinterface

`default_nettype wire

[rtl/cbml_rsp_if.sv]
// ----------------------------------------------------------------------------
// cbml_rsp_if
// Result channel: labels of a classify, the last one flagged.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbml_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] label_out;
   logic [3:0] box_index;
   logic       is_unknown;
   logic       last;

   modport source (
      output valid, label_out, box_index, is_unknown, last,
      input  ready
   );
   modport sink (
      input  valid, label_out, box_index, is_unknown, last,
      output ready
   );
endinterface

`default_nettype wire

[rtl/cbml_ram.sv]
// ----------------------------------------------------------------------------
// cbml_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/cbml_ctrl.sv]
// ----------------------------------------------------------------------------
// cbml_ctrl
// Sequencer: accepts items, walks the box table, orders result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module cbml_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_command,
   input  wire cbml_pkg::status_type stat,
   output logic                      req_ready,
   output cbml_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == cbml_pkg::CMD_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = stat.n_zero ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // a further match must wait for room in the output register
            if (!(stat.hit_more && !stat.out_free)) begin
               cmd.capture_first = stat.hit_first;
               cmd.push_match    = stat.hit_more;
               cmd.advance       = 1'b1;
               if (stat.j_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/cbml_dp.sv]
// ----------------------------------------------------------------------------
// cbml_dp
// Datapath: config registers, corner ordering, box tests, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbml_dp #(
   parameter int MAX_BOXES = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire cbml_pkg::cmd_type                         cmd,
   output cbml_pkg::status_type                           stat,
   // configuration
   input  wire logic                                      csr_we,
   input  wire logic [cbml_pkg::CSR_IDX_W-1:0]            csr_index,
   input  wire logic [cbml_pkg::CSR_DATA_W-1:0]           csr_wdata,
   // input payload
   input  wire logic [cbml_pkg::SLOT_W-1:0]               entry_index,
   input  wire logic [3*cbml_pkg::CHAN_W-1:0]             value_rgb,
   input  wire logic [3*cbml_pkg::CHAN_W-1:0]             other_rgb,
   input  wire logic [cbml_pkg::LABEL_W-1:0]              label_in,
   // table memory
   output logic                                           ram_we,
   output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] ram_waddr,
   output cbml_pkg::box_type                              ram_wdata,
   output logic [(MAX_BOXES > 1 ? $clog2(MAX_BOXES) : 1)-1:0] ram_raddr,
   input  wire cbml_pkg::box_type                         ram_rdata,
   // result
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_ready,
   output logic [cbml_pkg::LABEL_W-1:0]                   rsp_label,
   output logic [cbml_pkg::SLOT_W-1:0]                    rsp_index,
   output logic                                           rsp_unknown,
   output logic                                           rsp_last
);

   localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int NCAP = (MAX_BOXES < cbml_pkg::ADDR_SLOTS) ? MAX_BOXES
                                                            : cbml_pkg::ADDR_SLOTS;
   localparam int LW   = (AW + 1 > cbml_pkg::COUNT_W) ? AW + 1 : cbml_pkg::COUNT_W;
   localparam int CW   = cbml_pkg::CHAN_W;

   // configuration
   logic [cbml_pkg::COUNT_W-1:0] active_ff;
   logic [cbml_pkg::LABEL_W-1:0] unknown_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         unknown_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == cbml_pkg::CSR_ACTIVE_RANGES) begin
            active_ff <= csr_wdata[cbml_pkg::COUNT_W-1:0];
         end else if (csr_index == cbml_pkg::CSR_UNKNOWN_LABEL) begin
            unknown_ff <= csr_wdata[cbml_pkg::LABEL_W-1:0];
         end
      end
   end

   // load: order corners per channel
   always_comb begin
      ram_wdata.label = label_in;
      for (int c = 0; c < 3; c++) begin
         if (other_rgb[c*CW +: CW] > value_rgb[c*CW +: CW]) begin
            ram_wdata.low[c*CW +: CW]  = value_rgb[c*CW +: CW];
            ram_wdata.high[c*CW +: CW] = other_rgb[c*CW +: CW];
         end else begin
            ram_wdata.low[c*CW +: CW]  = other_rgb[c*CW +: CW];
            ram_wdata.high[c*CW +: CW] = value_rgb[c*CW +: CW];
         end
      end
   end

   assign ram_we    = cmd.load && (7'(entry_index) < 7'(MAX_BOXES));
   assign ram_waddr = AW'(entry_index);

   // scan position and effective box count
   logic [AW-1:0]                j_ff, j_in;
   logic [cbml_pkg::COUNT_W-1:0] n_ff;
   logic [cbml_pkg::COUNT_W-1:0] n_eff;
   cbml_pkg::rgb_type            px_ff;
   logic                         found_ff;

   assign n_eff = (active_ff > cbml_pkg::COUNT_W'(NCAP)) ? cbml_pkg::COUNT_W'(NCAP)
                                                         : active_ff;

   always_comb begin
      j_in = j_ff;
      if (cmd.start) begin
         j_in = '0;
      end else if (cmd.advance) begin
         j_in = j_ff + AW'(1);
      end
   end

   // read address follows the next scan position
   assign ram_raddr = j_in;

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      if (cmd.start) begin
         n_ff  <= n_eff;
         px_ff <= value_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.start) begin
         found_ff <= 1'b0;
      end else if (cmd.capture_first) begin
         found_ff <= 1'b1;
      end
   end

   // first match and pending result
   cbml_pkg::box_type            first_ff;
   logic [cbml_pkg::LABEL_W-1:0] pend_label_ff;
   logic [cbml_pkg::SLOT_W-1:0]  pend_index_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture_first) begin
         first_ff <= ram_rdata;
      end
      if (cmd.capture_first || cmd.push_match) begin
         pend_label_ff <= ram_rdata.label;
         pend_index_ff <= cbml_pkg::SLOT_W'(j_ff);
      end
   end

   // box tests on the entry read this cycle
   logic holds;
   logic overlap;

   always_comb begin
      logic [CW-1:0] lo_max;
      logic [CW-1:0] hi_min;
      holds   = 1'b1;
      overlap = 1'b1;
      for (int c = 0; c < 3; c++) begin
         if (px_ff[c*CW +: CW] < ram_rdata.low[c*CW +: CW] ||
             px_ff[c*CW +: CW] > ram_rdata.high[c*CW +: CW]) begin
            holds = 1'b0;
         end
         lo_max = (ram_rdata.low[c*CW +: CW] > first_ff.low[c*CW +: CW])
                  ? ram_rdata.low[c*CW +: CW] : first_ff.low[c*CW +: CW];
         hi_min = (ram_rdata.high[c*CW +: CW] < first_ff.high[c*CW +: CW])
                  ? ram_rdata.high[c*CW +: CW] : first_ff.high[c*CW +: CW];
         if (hi_min <= lo_max) begin
            overlap = 1'b0;
         end
      end
   end

   // result register
   logic                         rsp_valid_ff;
   logic [cbml_pkg::LABEL_W-1:0] rsp_label_ff;
   logic [cbml_pkg::SLOT_W-1:0]  rsp_index_ff;
   logic                         rsp_unknown_ff;
   logic                         rsp_last_ff;
   logic                         out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_match || cmd.emit_final) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_match) begin
         rsp_label_ff   <= pend_label_ff;
         rsp_index_ff   <= pend_index_ff;
         rsp_unknown_ff <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else if (cmd.emit_final) begin
         rsp_label_ff   <= found_ff ? pend_label_ff : unknown_ff;
         rsp_index_ff   <= found_ff ? pend_index_ff : '0;
         rsp_unknown_ff <= !found_ff;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_label   = rsp_label_ff;
   assign rsp_index   = rsp_index_ff;
   assign rsp_unknown = rsp_unknown_ff;
   assign rsp_last    = rsp_last_ff;

   // status
   assign stat.n_zero    = (active_ff == '0);
   assign stat.j_last    = (LW'(j_ff) + LW'(1)) == LW'(n_ff);
   assign stat.hit_first = !found_ff && holds;
   assign stat.hit_more  = found_ff && holds && overlap &&
                           (ram_rdata.label != first_ff.label);
   assign stat.out_free  = out_free;

endmodule

`default_nettype wire

[rtl/color_box_multilabel_classifier_top.sv]
// ----------------------------------------------------------------------------
// color_box_multilabel_classifier_top
// Classifies pixels against a table of labeled color boxes, emitting the
// first holding box's label plus differing labels of later holding boxes that overlap it.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake              payload
//  req_ch    in    valid / ready          command, entry_index, value_c*,
//                                         other_c*, label_in
//  rsp_ch    out   valid / ready          label_out, box_index, is_unknown,
//                                         last
//  csr_*     in    csr_we (no stall)      csr_index, csr_wdata
//
//  a load is taken in IDLE; the block accepts the next item right after
//  a classify is accepted in IDLE, then the scan reads and tests one box entry
//  per cycle from the table ram while it is not held (n = active boxes, at most
//  16), and a closing step emits the last or unknown label
//  a stalled result channel holds the scan when a further label is ready
//  reset is synchronous, active high; the box table is not cleared
//
`default_nettype none

module color_box_multilabel_classifier_top #(
   parameter int MAX_BOXES = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cbml_req_if.sink                                req_ch,
   cbml_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [cbml_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cbml_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   cbml_pkg::cmd_type    cmd;
   cbml_pkg::status_type stat;

   // table memory hookup
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [AW-1:0]        ram_raddr;
   cbml_pkg::box_type    ram_wdata;
   cbml_pkg::box_type    ram_rdata;

   // sequencer
   cbml_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .stat        (stat),
      .req_ready   (req_ch.ready),
      .cmd         (cmd)
   );

   // datapath, pixel and corners packed channel 0 in the low byte
   cbml_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .entry_index (req_ch.entry_index),
      .value_rgb   ({req_ch.value_c2, req_ch.value_c1, req_ch.value_c0}),
      .other_rgb   ({req_ch.other_c2, req_ch.other_c1, req_ch.other_c0}),
      .label_in    (req_ch.label_in),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_label   (rsp_ch.label_out),
      .rsp_index   (rsp_ch.box_index),
      .rsp_unknown (rsp_ch.is_unknown),
      .rsp_last    (rsp_ch.last)
   );

   // box table: bounds and label per slot
   cbml_ram #(
      .WIDTH ($bits(cbml_pkg::box_type)),
      .DEPTH (MAX_BOXES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire
